### rtl/crank_angle_to_trigger_event_defines.svh
// Assertion macros shared by the checker of the trigger event resolver.
// Each macro expands to one clocked concurrent assertion on clk, disabled in reset.
`ifndef CRANK_ANGLE_TO_TRIGGER_EVENT_DEFINES_SVH
`define CRANK_ANGLE_TO_TRIGGER_EVENT_DEFINES_SVH

// Same-cycle implication.
`define CATE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CATE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cate_pkg.sv
// Shared constants for the crank angle to trigger event resolver.
// Used by the top level and by its port checker; depends on nothing.
package cate_pkg;

  localparam int DEF_MAX_TEETH = 128;

  // One engine cycle of 720 degrees in 1/64-degree units.
  localparam int CYCLE_UNITS = 46080;
  localparam int DELAY_MIN   = -46080;
  localparam int DELAY_MAX   = 46079;

  localparam int ALU_W = 21;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  localparam logic [1:0] ST_RESOLVED = 2'd0;
  localparam logic [1:0] ST_LOADED   = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  localparam logic CFG_GLOBAL_OFFSET = 1'b0;
  localparam logic CFG_TOOTH_COUNT   = 1'b1;

endpackage

### rtl/crank_angle_to_trigger_event.sv
// Top level of the crank angle to trigger event resolver.
// Depends on cate_pkg for constants; holds the tooth table, sequencer and shared adder.

// A load beat stores one tooth angle and gives its result in the cycle after it is
// taken; a resolve beat with an empty table does the same. A resolve beat on a
// table of n teeth (n is tooth_count, limited to MAX_TEETH) steps through the sum,
// bias, reduction, first-tooth, scan and delay states, scanning teeth in order.
// Its run time is set by the single add/subtract unit, which does the offset add,
// the four-step reduction into the 720-degree cycle, and one tooth compare per
// cycle, and by the one read port of the tooth table. The block takes no new
// beat while a resolve is in progress. Table entries that were never loaded read
// back as unknown values, so load every tooth below tooth_count before resolving.
module crank_angle_to_trigger_event
  import cate_pkg::*;
#(
  parameter int MAX_TEETH = DEF_MAX_TEETH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic        [16:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic        [6:0]  in_tooth_index,
  input  logic        [15:0] in_tooth_angle,
  input  logic signed [18:0] in_event_angle,
  input  logic        [7:0]  in_event_tag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [1:0]  out_status,
  output logic        [6:0]  out_event_index,
  output logic signed [16:0] out_delay_angle,
  output logic        [7:0]  out_result_tag
);

  localparam int AW  = (MAX_TEETH > 1) ? $clog2(MAX_TEETH) : 1;
  localparam int NWR = $clog2(MAX_TEETH + 1);
  localparam int NW  = (NWR > 8) ? NWR : 8;

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_BIAS, S_MOD, S_FIRST, S_SCAN, S_DELAY
  } state_t;

  state_t                    state_r, state_nxt;
  logic signed [16:0]        off_r, off_nxt;
  logic        [7:0]         cnt_r, cnt_nxt;
  logic signed [18:0]        ev_r, ev_nxt;
  logic        [7:0]         tag_r, tag_nxt;
  logic signed [ALU_W-1:0]   acc_r, acc_nxt;
  logic        [15:0]        cur_ang_r, cur_ang_nxt;
  logic        [AW-1:0]      idx_r, idx_nxt;
  logic        [1:0]         k_r, k_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic        [1:0]         out_status_r, out_status_nxt;
  logic        [6:0]         out_idx_r, out_idx_nxt;
  logic signed [16:0]        out_delay_r, out_delay_nxt;
  logic        [7:0]         out_tag_r, out_tag_nxt;

  logic        [15:0]        mem [MAX_TEETH];
  logic        [15:0]        rd_q;
  logic        [AW-1:0]      rd_addr;
  logic                      mem_we;
  logic        [AW-1:0]      wr_addr;

  logic        [NW-1:0]      n_teeth;
  logic                      in_fire;
  logic signed [ALU_W-1:0]   alu_a, alu_b, alu_res;
  logic                      alu_sub;
  logic        [NW:0]        next_pos;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;

  assign n_teeth = (NW'(cnt_r) > NW'(MAX_TEETH)) ? NW'(MAX_TEETH) : NW'(cnt_r);
  assign next_pos = (NW + 1)'(idx_r) + (NW + 1)'(2);

  assign wr_addr = AW'(in_tooth_index);
  assign mem_we  = in_fire && (in_opcode == OP_LOAD) && (32'(in_tooth_index) < MAX_TEETH);

  assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_event_index = out_idx_r;
  assign out_delay_angle = out_delay_r;
  assign out_result_tag  = out_tag_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= in_tooth_angle;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    off_nxt        = off_r;
    cnt_nxt        = cnt_r;
    ev_nxt         = ev_r;
    tag_nxt        = tag_r;
    acc_nxt        = acc_r;
    cur_ang_nxt    = cur_ang_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_delay_nxt  = out_delay_r;
    out_tag_nxt    = out_tag_r;
    alu_a          = acc_r;
    alu_b          = '0;
    alu_sub        = 1'b0;
    rd_addr        = '0;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GLOBAL_OFFSET: off_nxt = cfg_data;
        CFG_TOOTH_COUNT:   cnt_nxt = cfg_data[7:0];
        default:           ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ev_nxt  = in_event_angle;
          tag_nxt = in_event_tag;
          if (in_opcode == OP_LOAD) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_LOADED;
            out_idx_nxt    = '0;
            out_delay_nxt  = '0;
            out_tag_nxt    = in_event_tag;
          end else if (n_teeth == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EMPTY;
            out_idx_nxt    = '0;
            out_delay_nxt  = '0;
            out_tag_nxt    = in_event_tag;
          end else begin
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        alu_a     = ALU_W'(ev_r);
        alu_b     = ALU_W'(off_r);
        acc_nxt   = alu_res;
        state_nxt = S_BIAS;
      end
      S_BIAS: begin
        // Adding 8 * CYCLE_UNITS makes any reachable sum non-negative and below 16 * CYCLE_UNITS.
        alu_b     = ALU_W'(8 * CYCLE_UNITS);
        acc_nxt   = alu_res;
        k_nxt     = 2'd3;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        alu_sub = 1'b1;
        alu_b   = ALU_W'(CYCLE_UNITS) <<< k_r;
        if (!alu_res[ALU_W-1]) begin
          acc_nxt = alu_res;
        end
        k_nxt = k_r - 2'd1;
        if (k_r == 2'd0) begin
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        // From here on the accumulator holds wrapped angle plus tooth 0 angle, so
        // each tooth compares against it directly.
        alu_b       = ALU_W'(rd_q);
        acc_nxt     = alu_res;
        cur_ang_nxt = rd_q;
        idx_nxt     = '0;
        rd_addr     = AW'(1);
        if (n_teeth == NW'(1)) begin
          state_nxt = S_DELAY;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        alu_sub = 1'b1;
        alu_b   = ALU_W'(rd_q);
        rd_addr = AW'(next_pos);
        if (alu_res[ALU_W-1]) begin
          state_nxt = S_DELAY;
        end else begin
          cur_ang_nxt = rd_q;
          idx_nxt     = idx_r + AW'(1);
          if (next_pos >= (NW + 1)'(n_teeth)) begin
            state_nxt = S_DELAY;
          end
        end
      end
      S_DELAY: begin
        alu_sub        = 1'b1;
        alu_b          = ALU_W'(cur_ang_r);
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_RESOLVED;
        out_idx_nxt    = 7'(idx_r);
        out_tag_nxt    = tag_r;
        if (alu_res < ALU_W'(DELAY_MIN)) begin
          out_delay_nxt = 17'(DELAY_MIN);
        end else if (alu_res > ALU_W'(DELAY_MAX)) begin
          out_delay_nxt = 17'(DELAY_MAX);
        end else begin
          out_delay_nxt = 17'(alu_res);
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      off_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      off_r       <= off_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ev_r         <= ev_nxt;
    tag_r        <= tag_nxt;
    acc_r        <= acc_nxt;
    cur_ang_r    <= cur_ang_nxt;
    idx_r        <= idx_nxt;
    k_r          <= k_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_delay_r  <= out_delay_nxt;
    out_tag_r    <= out_tag_nxt;
  end

endmodule

### rtl/cate_checker.sv
// Port-level checker for the trigger event resolver, bound to its top level.
// Depends on cate_pkg and the assertion macros in the defines header.
`include "crank_angle_to_trigger_event_defines.svh"

module cate_checker
  import cate_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic        [1:0]  out_status,
  input logic        [6:0]  out_event_index,
  input logic signed [16:0] out_delay_angle
);

  `CATE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_delay_angle), "result beat changed while stalled")
  `CATE_ASSERT_IMP(a_status_code, out_valid, out_status == ST_RESOLVED || out_status == ST_LOADED || out_status == ST_EMPTY, "unknown status code")
  `CATE_ASSERT_IMP(a_plain_zero, out_valid && out_status != ST_RESOLVED, out_event_index == 7'd0 && out_delay_angle == 17'sd0, "load or empty result carries nonzero fields")
  `CATE_ASSERT_IMP(a_delay_range, out_valid && out_status == ST_RESOLVED, out_delay_angle >= 17'(DELAY_MIN) && out_delay_angle <= 17'(DELAY_MAX), "delay outside one cycle")

endmodule

bind crank_angle_to_trigger_event cate_checker u_cate_checker (.*);

### sim/crank_angle_to_trigger_event_test.sv
// Self-checking testbench for the crank angle to trigger event resolver.
// Depends on cate_pkg and crank_angle_to_trigger_event; reads no files.
`timescale 1ns / 1ps

module crank_angle_to_trigger_event_test;
  import cate_pkg::*;

  localparam int TEETH = DEF_MAX_TEETH;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  index;
    logic [16:0] delay;
    logic [7:0]  tag;
  } trigger_result_t;

  // Mirrors the tooth table and registers, and queues the result each beat should give.
  class trigger_event_tracker;
    logic signed [16:0] offset_q;
    logic [7:0]         count_q;
    logic [15:0]        angles [TEETH];
    trigger_result_t    pending_results [$];
    int                 errors;

    function new();
      offset_q = '0;
      count_q  = '0;
      errors   = 0;
      foreach (angles[k]) angles[k] = '0;
    endfunction

    function void write_reg(logic idx, logic [16:0] data);
      if (idx == CFG_GLOBAL_OFFSET) offset_q = data;
      else count_q = data[7:0];
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_beat(logic op, logic [6:0] idx, logic [15:0] ang,
                            logic signed [18:0] ev, logic [7:0] tag);
      trigger_result_t r;
      int teeth, wrapped, first, rel, delay, k;
      bit scanning;
      r.status = ST_LOADED;
      r.index  = '0;
      r.delay  = '0;
      r.tag    = tag;
      teeth = (count_q > TEETH) ? TEETH : int'(count_q);
      if (op == OP_LOAD) begin
        angles[idx] = ang;
      end else if (teeth == 0) begin
        r.status = ST_EMPTY;
      end else begin
        wrapped = (int'(ev) + int'(offset_q)) % CYCLE_UNITS;
        if (wrapped < 0) wrapped += CYCLE_UNITS;
        first = int'(angles[0]);
        // Walk forward while the next tooth, relative to tooth 0, is not past the angle.
        k = 0;
        scanning = 1'b1;
        while (scanning && k + 1 < teeth) begin
          rel = int'(angles[k + 1]) - first;
          if (rel > wrapped) scanning = 1'b0;
          else k++;
        end
        delay = wrapped - (int'(angles[k]) - first);
        if (delay < DELAY_MIN) delay = DELAY_MIN;
        if (delay > DELAY_MAX) delay = DELAY_MAX;
        r.status = ST_RESOLVED;
        r.index  = k[6:0];
        r.delay  = delay[16:0];
      end
      pending_results.push_back(r);
    endfunction

    function void check_beat(trigger_result_t got);
      trigger_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: status %0d index %0d delay %0d tag %0d",
                 $time, got.status, got.index, $signed(got.delay), got.tag);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch: expected status %0d index %0d delay %0d tag %0d",
                 $time, want.status, want.index, $signed(want.delay), want.tag);
        $display("%0t:                  actual   status %0d index %0d delay %0d tag %0d",
                 $time, got.status, got.index, $signed(got.delay), got.tag);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [16:0] cfg_data;
  logic in_valid, in_ready, in_opcode;
  logic [6:0] in_tooth_index;
  logic [15:0] in_tooth_angle;
  logic signed [18:0] in_event_angle;
  logic [7:0] in_event_tag;
  logic out_valid, out_ready;
  logic [1:0] out_status;
  logic [6:0] out_event_index;
  logic signed [16:0] out_delay_angle;
  logic [7:0] out_result_tag;

  trigger_event_tracker tracker;
  bit steady = 1'b0;

  crank_angle_to_trigger_event dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_tooth_index(in_tooth_index), .in_tooth_angle(in_tooth_angle),
    .in_event_angle(in_event_angle), .in_event_tag(in_event_tag),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_event_index(out_event_index), .out_delay_angle(out_delay_angle),
    .out_result_tag(out_result_tag)
  );

  always #10 clk = ~clk;

  // Mostly back to back, sometimes a short gap, rarely a long pause; always back to back when steady is set.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady) return 0;
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  task automatic send_item(input logic op, input logic [6:0] idx, input logic [15:0] ang,
                           input logic signed [18:0] ev, input logic [7:0] tag);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_tooth_index <= idx;
    in_tooth_angle <= ang;
    in_event_angle <= ev;
    in_event_tag   <= tag;
    do @(posedge clk); while (!in_ready);
    tracker.note_beat(op, idx, ang, ev, tag);
  endtask

  task automatic load_tooth(input logic [6:0] idx, input logic [15:0] ang);
    send_item(OP_LOAD, idx, ang, 19'($urandom), 8'($urandom));
  endtask

  task automatic resolve_event(input logic signed [18:0] ev);
    send_item(OP_RESOLVE, 7'($urandom), 16'($urandom), ev, 8'($urandom));
  endtask

  // Drains the block, then writes both registers in two back-to-back beats.
  task automatic set_config(input logic [16:0] offset_word, input logic [7:0] count_value);
    logic [8:0] filler;
    filler = 9'($urandom);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_GLOBAL_OFFSET;
    cfg_data  <= offset_word;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(CFG_GLOBAL_OFFSET, offset_word);
    cfg_index <= CFG_TOOTH_COUNT;
    cfg_data  <= {filler, count_value};
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(CFG_TOOTH_COUNT, {filler, count_value});
    cfg_valid <= 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        tracker.check_beat({out_status, out_event_index, out_delay_angle, out_result_tag});
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int p, teeth, count_value, base, spacing, shape, rest, k, ev, roll, offset_value;
    tracker = new();
    rst_n          <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= CFG_GLOBAL_OFFSET;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_LOAD;
    in_tooth_index <= '0;
    in_tooth_angle <= '0;
    in_event_angle <= '0;
    in_event_tag   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table straight out of reset, with the event angle and tag extremes.
    send_item(OP_RESOLVE, 7'd0, 16'd0, 19'sd262143, 8'h00);
    send_item(OP_RESOLVE, 7'd127, 16'hFFFF, -19'sd262144, 8'hFF);
    load_tooth(7'd127, 16'hFFFF);
    load_tooth(7'd0, 16'd0);
    load_tooth(7'd1, 16'd46079);
    load_tooth(7'd2, 16'd100);
    load_tooth(7'd3, 16'd23040);

    // A non-monotonic table: wrap edges and exact tooth hits.
    set_config(17'd0, 8'd4);
    resolve_event(19'sd0);
    resolve_event(19'sd46079);
    resolve_event(19'sd46080);
    resolve_event(-19'sd1);
    resolve_event(19'sd184320);
    resolve_event(-19'sd184320);
    resolve_event(19'sd100);
    resolve_event(19'sd99);

    set_config(17'sd46080, 8'd3);
    resolve_event(-19'sd46080);
    resolve_event(19'sd184320);

    // A tooth 0 above the cycle makes later relative angles negative, so the delay saturates.
    set_config(-17'sd46080, 8'd1);
    resolve_event(19'sd0);
    load_tooth(7'd0, 16'hFFFF);
    set_config(17'h0FFFF, 8'd4);
    resolve_event(19'sd0);
    resolve_event(-19'sd262144);
    resolve_event(19'sd262143);

    for (p = 0; p < 16; p++) begin
      roll = $urandom_range(0, 99);
      case (p)
        0: offset_value = 46080;
        1: offset_value = -46080;
        2: offset_value = 65535;
        3: offset_value = -65536;
        4: offset_value = 0;
        default: offset_value = (roll < 80) ? int'($urandom_range(0, 92160)) - 46080
                                            : int'($urandom);
      endcase
      case (p)
        0: count_value = 255;
        1: count_value = 128;
        2: count_value = 1;
        3: count_value = 2;
        4: count_value = 0;
        5: count_value = 200;
        default: count_value = (roll < 75) ? $urandom_range(1, 16) : $urandom_range(17, 64);
      endcase
      teeth = (count_value > TEETH) ? TEETH : count_value;
      set_config(offset_value[16:0], count_value[7:0]);
      steady = (p % 6 == 4);

      // Build a table of teeth below the count first, so no unloaded entry is read.
      if (teeth > 0) begin
        shape   = $urandom_range(0, 99);
        base    = (shape < 70) ? $urandom_range(0, 2000) : $urandom_range(0, 46079);
        spacing = 46080 / teeth;
        for (k = 0; k < teeth; k++) begin
          if (shape < 85) load_tooth(k[6:0], 16'(base + k * spacing + $urandom_range(0, spacing / 4)));
          else load_tooth(k[6:0], 16'($urandom));
        end
      end

      rest = (teeth > 70) ? 30 : 100 - teeth / 2;
      repeat (rest) begin
        if ($urandom_range(0, 99) < 18) begin
          load_tooth(7'($urandom), ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 46079))
                                                                : 16'($urandom));
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 20 && teeth > 0) begin
            // Land on or right next to a tooth edge after the offset is applied.
            k  = $urandom_range(0, teeth - 1);
            ev = int'(tracker.angles[k]) - int'(tracker.angles[0]) - int'(tracker.offset_q)
                 + int'($urandom_range(0, 2)) - 1;
          end else if (roll < 60) begin
            ev = $urandom_range(0, 46079);
          end else if (roll < 85) begin
            ev = int'($urandom_range(0, 368640)) - 184320;
          end else begin
            ev = $urandom;
          end
          resolve_event(ev[18:0]);
        end
      end
    end

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
